FILE: rtl/skf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants of the scalar Kalman filter
// Field widths, configuration register indexes, reset values and the status
// record that the serial arithmetic units return.
// ----------------------------------------------------------------------------
package skf_pkg;

  // Widths of the external fields.
  localparam int FIELD_W     = 32;
  localparam int NOISE_W     = 31;
  localparam int CFG_INDEX_W = 2;

  typedef logic signed [FIELD_W-1:0] word_t;
  typedef logic        [NOISE_W-1:0] noise_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PROCESS_NOISE      = 2'd0,
    REG_MEASUREMENT_NOISE  = 2'd1,
    REG_INITIAL_ESTIMATE   = 2'd2,
    REG_INITIAL_COVARIANCE = 2'd3
  } cfg_index_t;

  // Reset values of the configuration registers (noise UQ15.16, initial values Q16.16).
  localparam noise_t RST_PROCESS_NOISE      = 31'd6554;
  localparam noise_t RST_MEASUREMENT_NOISE  = 31'd6554;
  localparam word_t  RST_INITIAL_ESTIMATE   = 32'sd327680;
  localparam word_t  RST_INITIAL_COVARIANCE = -32'sd13107;

  // Status returned by a serial divider or multiplier.
  typedef struct packed {
    logic done;
    logic sat;
  } unit_status_t;

endpackage
`default_nettype wire

FILE: rtl/skf_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skf_in_if: measurement channel
// Carries one measurement item with its reload flag under valid/ready.
// ----------------------------------------------------------------------------
interface skf_in_if;
  import skf_pkg::*;

  logic  valid;
  logic  ready;
  word_t measurement;
  logic  reload;

  modport source (output valid, output measurement, output reload, input ready);
  modport sink   (input valid, input measurement, input reload, output ready);
endinterface
`default_nettype wire

FILE: rtl/skf_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skf_out_if: result channel
// Carries one filter result item per measurement under valid/ready.
// ----------------------------------------------------------------------------
interface skf_out_if;
  import skf_pkg::*;

  logic  valid;
  logic  ready;
  word_t estimate;
  word_t gain;
  word_t error_cov;
  logic  step_error;
  logic  any_error;

  modport source (output valid, output estimate, output gain, output error_cov,
                  output step_error, output any_error, input ready);
  modport sink   (input valid, input estimate, input gain, input error_cov,
                  input step_error, input any_error, output ready);
endinterface
`default_nettype wire

FILE: rtl/skf_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skf_cfg_if: configuration write channel
// Carries a register index and write data under valid/ready.
// ----------------------------------------------------------------------------
interface skf_cfg_if;
  import skf_pkg::*;

  logic       valid;
  logic       ready;
  cfg_index_t index;
  word_t      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/skf_serial_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skf_serial_div: bit-serial fixed-point divider
// Computes (num << FB) / den on magnitudes, one quotient bit per cycle by
// restoring division, then applies the sign and saturates to NW bits.
// ----------------------------------------------------------------------------
module skf_serial_div #(
  parameter int NW = 32,
  parameter int DW = 34,
  parameter int FB = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic signed [NW-1:0]   num,
  input  wire logic signed [DW-1:0]   den,
  output logic signed [NW-1:0]        quot,
  output skf_pkg::unit_status_t       status
);
  import skf_pkg::*;

  localparam int NB = NW + FB;
  localparam int CW = $clog2(NB + 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} div_state_t;

  div_state_t     state;
  logic [CW-1:0]  cnt;
  logic           neg;
  logic [NB-1:0]  dvd;
  logic [DW-1:0]  dsr;
  logic [DW-1:0]  rem;
  logic [NB-1:0]  qt;

  logic [NW-1:0]  num_u;
  logic [DW-1:0]  den_u;
  logic [NW-1:0]  num_mag;
  logic [DW-1:0]  den_mag;
  logic [DW:0]    rem_sh;
  logic [DW+1:0]  diff;
  logic           ge;
  logic [DW-1:0]  rem_next;
  logic           hi_nz;
  logic           exact_min;
  logic           q_sat;
  logic [NW-1:0]  q_mag;
  logic [NW-1:0]  q_word;

  // Operand magnitudes taken at start.
  always_comb begin
    num_u   = num;
    den_u   = den;
    num_mag = num_u[NW-1] ? (~num_u + NW'(1)) : num_u;
    den_mag = den_u[DW-1] ? (~den_u + DW'(1)) : den_u;
  end

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_sh   = {rem, dvd[NB-1]};
    diff     = {1'b0, rem_sh} - {2'b00, dsr};
    ge       = ~diff[DW+1];
    rem_next = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
  end

  // Sign and saturation of the finished quotient.
  always_comb begin
    hi_nz     = |qt[NB-1:NW-1];
    exact_min = qt[NW-1] && !(|qt[NB-1:NW]) && !(|qt[NW-2:0]);
    q_sat     = hi_nz && !(neg && exact_min);
    q_mag     = qt[NW-1:0];
    if (q_sat) begin
      q_word = neg ? {1'b1, {(NW-1){1'b0}}} : {1'b0, {(NW-1){1'b1}}};
    end else begin
      q_word = neg ? (~q_mag + NW'(1)) : q_mag;
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= D_IDLE;
      status.done <= 1'b0;
      status.sat  <= 1'b0;
      cnt         <= '0;
    end else begin
      status.done <= (state == D_FIN);
      case (state)
        D_IDLE: begin
          if (start) begin
            neg   <= num[NW-1] ^ den[DW-1];
            dvd   <= {num_mag, {FB{1'b0}}};
            dsr   <= den_mag;
            rem   <= '0;
            qt    <= '0;
            cnt   <= CW'(NB);
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= rem_next;
          dvd <= {dvd[NB-2:0], 1'b0};
          qt  <= {qt[NB-2:0], ge};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          quot       <= q_word;
          status.sat <= q_sat;
          state      <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/skf_serial_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skf_serial_mul: bit-serial fixed-point multiplier
// Forms |a| * |b| by shift and add, one multiplier bit per cycle, then drops
// FB fraction bits, applies the sign and saturates to AW bits.
// ----------------------------------------------------------------------------
module skf_serial_mul #(
  parameter int AW = 32,
  parameter int BW = 34,
  parameter int FB = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic signed [AW-1:0]   a,
  input  wire logic signed [BW-1:0]   b,
  output logic signed [AW-1:0]        prod,
  output skf_pkg::unit_status_t       status
);
  import skf_pkg::*;

  localparam int PW = AW + BW;
  localparam int CW = $clog2(AW + 1);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mul_state_t;

  mul_state_t     state;
  logic [CW-1:0]  cnt;
  logic           neg;
  logic [BW-1:0]  hi;
  logic [AW-1:0]  lo;
  logic [BW-1:0]  mcand;

  logic [AW-1:0]  a_u;
  logic [BW-1:0]  b_u;
  logic [AW-1:0]  a_mag;
  logic [BW-1:0]  b_mag;
  logic [BW:0]    sum;
  logic [PW-1:0]  full;
  logic           hi_nz;
  logic           exact_min;
  logic           p_sat;
  logic [AW-1:0]  p_mag;
  logic [AW-1:0]  p_word;

  // Operand magnitudes taken at start.
  always_comb begin
    a_u   = a;
    b_u   = b;
    a_mag = a_u[AW-1] ? (~a_u + AW'(1)) : a_u;
    b_mag = b_u[BW-1] ? (~b_u + BW'(1)) : b_u;
  end

  // One shift-and-add step on the upper half of the product.
  always_comb begin
    sum = {1'b0, hi} + {1'b0, (lo[0] ? mcand : {BW{1'b0}})};
  end

  // Scaling, sign and saturation of the finished product.
  always_comb begin
    full      = {hi, lo};
    hi_nz     = |full[PW-1:FB+AW-1];
    exact_min = full[FB+AW-1] && !(|full[PW-1:FB+AW]) && !(|full[FB+AW-2:FB]);
    p_sat     = hi_nz && !(neg && exact_min);
    p_mag     = full[FB+AW-1:FB];
    if (p_sat) begin
      p_word = neg ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    end else begin
      p_word = neg ? (~p_mag + AW'(1)) : p_mag;
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= M_IDLE;
      status.done <= 1'b0;
      status.sat  <= 1'b0;
      cnt         <= '0;
    end else begin
      status.done <= (state == M_FIN);
      case (state)
        M_IDLE: begin
          if (start) begin
            neg   <= a[AW-1] ^ b[BW-1];
            hi    <= '0;
            lo    <= a_mag;
            mcand <= b_mag;
            cnt   <= CW'(AW);
            state <= M_RUN;
          end
        end
        M_RUN: begin
          hi  <= sum[BW:1];
          lo  <= {sum[0], lo[AW-1:1]};
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= M_FIN;
          end
        end
        M_FIN: begin
          prod       <= p_word;
          status.sat <= p_sat;
          state      <= M_IDLE;
        end
        default: begin
          state <= M_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/scalar_kalman_filter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core: one-dimensional Kalman filter, signed fixed point
// Each measurement item runs one predict/update step and yields one result
// item with the new estimate, gain and covariance plus error flags.
// ----------------------------------------------------------------------------
//
//   channel   role    handshake      payload
//   sample    sink    valid/ready    measurement, reload
//   result    source  valid/ready    estimate, gain, error_cov, step_error,
//                                    any_error
//   cfg       sink    valid/ready    index, data (always ready)
//
// Each item runs through the bit-serial divider (one quotient bit per cycle)
// and then the two bit-serial multipliers, which run side by side. A zero
// divisor skips the divider.
// A new item is accepted as soon as the previous one has
// moved into the result register, even while that result waits to be taken.
// Reset is synchronous; it restores the configuration registers and loads
// estimate and covariance from the initial values. A stalled result only
// holds the step once it is finished.
//
module scalar_kalman_filter_core #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  skf_in_if.sink    sample,
  skf_out_if.source result,
  skf_cfg_if.sink   cfg
);
  import skf_pkg::*;

  // Internal width that holds every exact sum without overflow.
  localparam int W  = DATA_WIDTH;
  localparam int XW = ((W > FIELD_W) ? W : FIELD_W) + 2;

  localparam logic signed [XW-1:0] WMAX_X = XW'({(W-1){1'b1}});
  localparam logic signed [XW-1:0] WMIN_X = ~WMAX_X;
  localparam logic signed [W-1:0]  WMAX_W = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  WMIN_W = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [XW-1:0] ONE_X  = XW'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_P1, S_DEN, S_DSTART, S_DWAIT, S_OPER, S_MSTART, S_MWAIT,
    S_XUPD, S_DONE
  } core_state_t;

  // Clamp an exact value to the data word.
  function automatic logic signed [W-1:0] clamp_w(input logic signed [XW-1:0] v);
    if (v > WMAX_X) begin
      return WMAX_W;
    end else if (v < WMIN_X) begin
      return WMIN_W;
    end
    return v[W-1:0];
  endfunction

  function automatic logic out_of_range(input logic signed [XW-1:0] v);
    return (v > WMAX_X) || (v < WMIN_X);
  endfunction

  // Configuration registers.
  noise_t q_reg;
  noise_t r_reg;
  word_t  init_est;
  word_t  init_cov;

  // Filter state and per-step registers.
  core_state_t            state;
  logic signed [W-1:0]    est_reg;
  logic signed [W-1:0]    cov_reg;
  logic                   err_latch;
  logic                   step_err;
  word_t                  m_reg;
  logic signed [W-1:0]    p1;
  logic signed [XW-1:0]   den;
  logic signed [W-1:0]    k_reg;
  logic signed [XW-1:0]   b1;
  logic signed [XW-1:0]   b2;
  logic signed [W-1:0]    x_new;

  logic signed [XW-1:0]   p1_sum;
  logic signed [XW-1:0]   den_sum;
  logic signed [XW-1:0]   x_sum;
  logic                   div_start;
  logic                   mul_start;
  logic signed [W-1:0]    div_quot;
  logic signed [W-1:0]    mul1_prod;
  logic signed [W-1:0]    mul2_prod;
  unit_status_t           div_st;
  unit_status_t           mul1_st;
  unit_status_t           mul2_st;

  // Configuration writes; indexes past the list are ignored.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_reg    <= RST_PROCESS_NOISE;
      r_reg    <= RST_MEASUREMENT_NOISE;
      init_est <= RST_INITIAL_ESTIMATE;
      init_cov <= RST_INITIAL_COVARIANCE;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PROCESS_NOISE:      q_reg    <= cfg.data[NOISE_W-1:0];
        REG_MEASUREMENT_NOISE:  r_reg    <= cfg.data[NOISE_W-1:0];
        REG_INITIAL_ESTIMATE:   init_est <= cfg.data;
        REG_INITIAL_COVARIANCE: init_cov <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Exact sums for the predict, divisor and estimate update steps.
  always_comb begin
    p1_sum  = $signed(XW'(cov_reg)) + $signed(XW'(q_reg));
    den_sum = $signed(XW'(p1)) + $signed(XW'(r_reg));
    x_sum   = $signed(XW'(est_reg)) + $signed(XW'(mul1_prod));
  end

  assign div_start    = (state == S_DSTART) && (den != '0);
  assign mul_start    = (state == S_MSTART);
  assign sample.ready = (state == S_IDLE);

  // Gain k = p1 / (p1 + r).
  skf_serial_div #(
    .NW (W),
    .DW (XW),
    .FB (FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (p1),
    .den    (den),
    .quot   (div_quot),
    .status (div_st)
  );

  // Correction k * (m - x).
  skf_serial_mul #(
    .AW (W),
    .BW (XW),
    .FB (FRAC_BITS)
  ) u_mul_x (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (k_reg),
    .b      (b1),
    .prod   (mul1_prod),
    .status (mul1_st)
  );

  // Covariance p1 * (1 - k).
  skf_serial_mul #(
    .AW (W),
    .BW (XW),
    .FB (FRAC_BITS)
  ) u_mul_p (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (p1),
    .b      (b2),
    .prod   (mul2_prod),
    .status (mul2_st)
  );

  // Step sequencer, filter state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result.valid <= 1'b0;
      est_reg      <= clamp_w(XW'(RST_INITIAL_ESTIMATE));
      cov_reg      <= clamp_w(XW'(RST_INITIAL_COVARIANCE));
      err_latch    <= 1'b0;
      step_err     <= 1'b0;
    end else begin
      // A taken result clears valid unless a new one replaces it below.
      if (result.valid && result.ready && (state != S_DONE)) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            m_reg    <= sample.measurement;
            step_err <= 1'b0;
            if (sample.reload) begin
              est_reg   <= clamp_w(XW'(init_est));
              cov_reg   <= clamp_w(XW'(init_cov));
              err_latch <= 1'b0;
            end
            state <= S_P1;
          end
        end
        S_P1: begin
          p1 <= clamp_w(p1_sum);
          if (out_of_range(p1_sum)) begin
            step_err <= 1'b1;
          end
          state <= S_DEN;
        end
        S_DEN: begin
          den   <= den_sum;
          state <= S_DSTART;
        end
        S_DSTART: begin
          // A zero divisor gives a zero gain and flags the step.
          if (den == '0) begin
            k_reg    <= '0;
            step_err <= 1'b1;
            state    <= S_OPER;
          end else begin
            state <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          if (div_st.done) begin
            k_reg <= div_quot;
            if (div_st.sat) begin
              step_err <= 1'b1;
            end
            state <= S_OPER;
          end
        end
        S_OPER: begin
          b1    <= $signed(XW'(m_reg)) - $signed(XW'(est_reg));
          b2    <= ONE_X - $signed(XW'(k_reg));
          state <= S_MSTART;
        end
        S_MSTART: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mul1_st.done) begin
            if (mul1_st.sat || mul2_st.sat) begin
              step_err <= 1'b1;
            end
            state <= S_XUPD;
          end
        end
        S_XUPD: begin
          x_new <= clamp_w(x_sum);
          if (out_of_range(x_sum)) begin
            step_err <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result.valid || result.ready) begin
            result.valid      <= 1'b1;
            result.estimate   <= FIELD_W'(x_new);
            result.gain       <= FIELD_W'(k_reg);
            result.error_cov  <= FIELD_W'(mul2_prod);
            result.step_error <= step_err;
            result.any_error  <= err_latch | step_err;
            est_reg           <= x_new;
            cov_reg           <= mul2_prod;
            err_latch         <= err_latch | step_err;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The two multipliers start together and must finish together.
  a_mul_lockstep: assert property (@(posedge clk) disable iff (rst)
    mul1_st.done == mul2_st.done)
    else $error("multipliers finished out of step");

  // A quotient only arrives while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == S_DWAIT))
    else $error("divider finished outside its wait state");

  // A zero divisor forces a zero gain.
  a_zero_den_gain: assert property (@(posedge clk) disable iff (rst)
    (state == S_DSTART && den == '0) |=> (k_reg == '0))
    else $error("zero divisor did not clear the gain");

  // A flagged step always shows in the sticky flag.
  a_sticky_flag: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.step_error) |-> result.any_error)
    else $error("step error missing from sticky flag");

endmodule
`default_nettype wire
